[src/cdxt1_pkg.sv]
// Shared types and constants for the tiled DXT1 block decoder.
// No dependencies; every other source file imports this package.
`default_nettype none

package cdxt1_pkg;

    localparam int CDXT1_MAX_SIDE_BLOCKS = 256;

    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_BLOCKS  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_BLOCKS = 1'b1;

    localparam logic [CFG_DATA_W-1:0] SIDE_BLOCKS_RESET = 9'd256;

    typedef struct packed {
        logic [15:0] endpoint_first;
        logic [15:0] endpoint_second;
        logic [31:0] index_bits;
    } in_t;

    typedef struct packed {
        logic [7:0]  block_x;
        logic [7:0]  block_y;
        logic [1:0]  row_in_block;
        logic [31:0] pixel_left;
        logic [31:0] pixel_mid_left;
        logic [31:0] pixel_mid_right;
        logic [31:0] pixel_right;
        logic        last_row;
        logic        last_block;
    } out_t;

    // Position of one block in the image, carried alongside its data.
    typedef struct packed {
        logic [7:0] block_x;
        logic [7:0] block_y;
        logic       last_block;
    } pos_t;

    // Four BGRA palette entries, entry 0 in the low word.
    typedef logic [3:0][31:0] palette_t;

endpackage

`default_nettype wire

[src/cdxt1_position.sv]
// Image size registers and the tile-order block position counters.
// Depends on cdxt1_pkg.
`default_nettype none

module cdxt1_position
    import cdxt1_pkg::*;
#(
    parameter int MAX_SIDE_BLOCKS = CDXT1_MAX_SIDE_BLOCKS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   advance,
    output pos_t                        pos
);

    localparam int HALF_SIDE = MAX_SIDE_BLOCKS / 2;
    localparam int TILE_LIM  = (HALF_SIDE > 128) ? 128 : ((HALF_SIDE < 1) ? 1 : HALF_SIDE);
    localparam logic [7:0] TILE_LIM_W = 8'(TILE_LIM);

    logic [CFG_DATA_W-1:0] width_reg, width_next;
    logic [CFG_DATA_W-1:0] height_reg, height_next;
    logic [6:0] tile_col_reg, tile_col_next;
    logic [6:0] tile_row_reg, tile_row_next;
    logic [1:0] sub_reg, sub_next;

    logic [7:0] tiles_w, tiles_h;
    logic       col_end, row_end;

    // Tile count per side: half the block count, at least one, at most the limit.
    function automatic logic [7:0] tile_count(input logic [CFG_DATA_W-1:0] blocks);
        logic [7:0] t;
        t = blocks[8:1];
        if (t == 8'd0) begin
            t = 8'd1;
        end
        if (t > TILE_LIM_W) begin
            t = TILE_LIM_W;
        end
        return t;
    endfunction

    always_comb begin
        tiles_w = tile_count(width_reg);
        tiles_h = tile_count(height_reg);
        col_end = ({1'b0, tile_col_reg} + 8'd1) >= tiles_w;
        row_end = ({1'b0, tile_row_reg} + 8'd1) >= tiles_h;

        pos.block_x    = {tile_col_reg, sub_reg[0]};
        pos.block_y    = {tile_row_reg, sub_reg[1]};
        pos.last_block = (sub_reg == 2'd3) && col_end && row_end;
    end

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WIDTH_BLOCKS:  width_next  = cfg_wdata;
                REG_HEIGHT_BLOCKS: height_next = cfg_wdata;
                default:           ;
            endcase
        end
    end

    always_comb begin
        sub_next      = sub_reg;
        tile_col_next = tile_col_reg;
        tile_row_next = tile_row_reg;
        if (advance) begin
            sub_next = sub_reg + 2'd1;
            if (sub_reg == 2'd3) begin
                if (col_end) begin
                    tile_col_next = 7'd0;
                    tile_row_next = row_end ? 7'd0 : tile_row_reg + 7'd1;
                end else begin
                    tile_col_next = tile_col_reg + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= SIDE_BLOCKS_RESET;
            height_reg   <= SIDE_BLOCKS_RESET;
            tile_col_reg <= 7'd0;
            tile_row_reg <= 7'd0;
            sub_reg      <= 2'd0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            tile_col_reg <= tile_col_next;
            tile_row_reg <= tile_row_next;
            sub_reg      <= sub_next;
        end
    end

endmodule

`default_nettype wire

[src/cdxt1_palette.sv]
// Combinational four-entry BGRA palette from two RGB565 endpoints.
// Depends on cdxt1_pkg.
`default_nettype none

module cdxt1_palette
    import cdxt1_pkg::*;
(
    input  wire logic [15:0] endpoint_first,
    input  wire logic [15:0] endpoint_second,
    output palette_t         palette
);

    logic [2:0][7:0] ch_a, ch_b, mid2, mid3;
    logic            four_color;

    function automatic logic [2:0][7:0] expand565(input logic [15:0] c);
        logic [2:0][7:0] ch;
        ch[0] = {c[4:0], c[4:2]};
        ch[1] = {c[10:5], c[10:9]};
        ch[2] = {c[15:11], c[15:13]};
        return ch;
    endfunction

    // x / 3 for x below 768 as (x * 683) >> 11.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] prod;
        prod = {11'd0, x} * 21'd683;
        return prod[18:11];
    endfunction

    function automatic logic [31:0] pack_bgra(input logic [2:0][7:0] ch, input logic [7:0] alpha);
        return {alpha, ch[2], ch[1], ch[0]};
    endfunction

    always_comb begin
        logic [9:0] sum_2a_b;
        logic [9:0] sum_a_2b;
        logic [8:0] sum_a_b;
        ch_a       = expand565(endpoint_first);
        ch_b       = expand565(endpoint_second);
        four_color = endpoint_first > endpoint_second;
        for (int c = 0; c < 3; c++) begin
            sum_2a_b = {1'b0, ch_a[c], 1'b0} + {2'b00, ch_b[c]} + 10'd1;
            sum_a_2b = {2'b00, ch_a[c]} + {1'b0, ch_b[c], 1'b0} + 10'd1;
            sum_a_b  = {1'b0, ch_a[c]} + {1'b0, ch_b[c]} + 9'd1;
            mid2[c]  = four_color ? div3(sum_2a_b) : sum_a_b[8:1];
            mid3[c]  = div3(sum_a_2b);
        end
        palette[0] = pack_bgra(ch_a, 8'hFF);
        palette[1] = pack_bgra(ch_b, 8'hFF);
        palette[2] = pack_bgra(mid2, 8'hFF);
        // Three-color blocks make the last entry transparent.
        palette[3] = pack_bgra(mid3, four_color ? 8'hFF : 8'h00);
    end

endmodule

`default_nettype wire

[src/cdxt1_row_emit.sv]
// Palette stage and result register: sends a block's four pixel rows in order.
// Depends on cdxt1_pkg.
`default_nettype none

module cdxt1_row_emit
    import cdxt1_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire palette_t    load_palette,
    input  wire logic [31:0] load_index_bits,
    input  wire pos_t        load_pos,
    output logic             take,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data
);

    logic       blk_valid_reg, blk_valid_next;
    logic [1:0] row_reg, row_next;
    palette_t   pal_reg;
    logic [31:0] idx_reg;
    pos_t       pos_reg;
    logic       m_valid_reg, m_valid_next;
    out_t       m_data_reg, m_data_next;

    logic       out_load, emit, row_done;
    logic [7:0] row_idx;

    assign out_load = !m_valid_reg || m_ready;
    assign emit     = blk_valid_reg && out_load;
    assign row_done = emit && (row_reg == 2'd3);
    assign take     = !blk_valid_reg || row_done;

    always_comb begin
        unique case (row_reg)
            2'd0: row_idx = idx_reg[31:24];
            2'd1: row_idx = idx_reg[23:16];
            2'd2: row_idx = idx_reg[15:8];
            2'd3: row_idx = idx_reg[7:0];
            default: row_idx = idx_reg[31:24];
        endcase

        m_data_next.block_x         = pos_reg.block_x;
        m_data_next.block_y         = pos_reg.block_y;
        m_data_next.row_in_block    = row_reg;
        m_data_next.pixel_left      = pal_reg[row_idx[7:6]];
        m_data_next.pixel_mid_left  = pal_reg[row_idx[5:4]];
        m_data_next.pixel_mid_right = pal_reg[row_idx[3:2]];
        m_data_next.pixel_right     = pal_reg[row_idx[1:0]];
        m_data_next.last_row        = (row_reg == 2'd3);
        m_data_next.last_block      = pos_reg.last_block;
    end

    always_comb begin
        blk_valid_next = blk_valid_reg;
        row_next       = row_reg;
        if (load) begin
            blk_valid_next = 1'b1;
            row_next       = 2'd0;
        end else if (emit) begin
            blk_valid_next = !row_done;
            row_next       = row_reg + 2'd1;
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_valid_reg <= 1'b0;
            row_reg       <= 2'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            blk_valid_reg <= blk_valid_next;
            row_reg       <= row_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pal_reg <= load_palette;
            idx_reg <= load_index_bits;
            pos_reg <= load_pos;
        end
        if (emit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[src/cmpr_dxt1_block_decoder_unit.sv]
// Top level of the tiled DXT1 block decoder: input register, palette, row output.
// Depends on cdxt1_pkg, cdxt1_position, cdxt1_palette and cdxt1_row_emit.
//
//  Channel  Ports                          Carries
//  input    s_valid / s_ready / s_data     one 8-byte compressed block
//  result   m_valid / m_ready / m_data     one row of four BGRA pixels
//  config   cfg_wr_en / cfg_index / cfg_wdata   width and height in blocks
//
// A block is held in the input register, then its palette is loaded into the
// row stage, and each row of the block is then registered in the result register.
// Rows leave one per cycle while m_ready does not stall the result channel; the
// block rate is set by the single result register that carries one row at a time.
// The input register takes the next block while the row stage is still busy.
// Reset (aresetn low, synchronous) empties all stages and returns to the first block.
`default_nettype none

module cmpr_dxt1_block_decoder_unit
    import cdxt1_pkg::*;
#(
    parameter int MAX_SIDE_BLOCKS = CDXT1_MAX_SIDE_BLOCKS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_t                    s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_t                        m_data
);

    logic     in_valid_reg, in_valid_next;
    in_t      in_data_reg;
    pos_t     in_pos_reg;
    pos_t     cur_pos;
    palette_t palette;
    logic     s_accept, blk_load, row_take;

    assign s_ready  = !in_valid_reg || row_take;
    assign s_accept = s_valid && s_ready;
    assign blk_load = in_valid_reg && row_take;

    cdxt1_position #(
        .MAX_SIDE_BLOCKS(MAX_SIDE_BLOCKS)
    ) u_position (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (s_accept),
        .pos       (cur_pos)
    );

    cdxt1_palette u_palette (
        .endpoint_first  (in_data_reg.endpoint_first),
        .endpoint_second (in_data_reg.endpoint_second),
        .palette         (palette)
    );

    cdxt1_row_emit u_row_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (blk_load),
        .load_palette    (palette),
        .load_index_bits (in_data_reg.index_bits),
        .load_pos        (in_pos_reg),
        .take            (row_take),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (blk_load) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_data;
            in_pos_reg  <= cur_pos;
        end
    end

endmodule

`default_nettype wire

[src/cdxt1_checker.sv]
// Port-level checks for the DXT1 block decoder, bound to the top level.
// Depends on cdxt1_pkg and cmpr_dxt1_block_decoder_unit.
`default_nettype none

module cdxt1_checker
    import cdxt1_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    // A stalled result request keeps its row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // The last-row flag marks exactly the fourth row of a block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_row == (m_data.row_in_block == 2'd3)))
        else $error("last_row does not match row_in_block");

    // The final block of an image is always the bottom-right block of a tile.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last_block |-> m_data.block_x[0] && m_data.block_y[0])
        else $error("last_block outside bottom-right sub-block");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Reset leaves the input side able to take a request.
    assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind cmpr_dxt1_block_decoder_unit cdxt1_checker u_cdxt1_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the tiled DXT1 block decoder: random and directed blocks,
// several image sizes, random stalls on both channels. Depends on cdxt1_pkg and the RTL.

module tb;
    import cdxt1_pkg::*;

    // Expected decoded rows, kept in step with the requests accepted by the decoder.
    class dxt1_row_board;
        logic [8:0] width_reg;
        logic [8:0] height_reg;
        logic [6:0] tile_col;
        logic [6:0] tile_row;
        logic [1:0] quad;
        out_t rows_due[$];
        int unsigned mismatches;
        int unsigned rows_checked;
        int unsigned image_ends;

        function new();
            width_reg = SIDE_BLOCKS_RESET;
            height_reg = SIDE_BLOCKS_RESET;
            tile_col = '0;
            tile_row = '0;
            quad = '0;
            mismatches = 0;
            rows_checked = 0;
            image_ends = 0;
        endfunction

        function void set_size(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_WIDTH_BLOCKS) begin
                width_reg = val;
            end else if (idx == REG_HEIGHT_BLOCKS) begin
                height_reg = val;
            end
        endfunction

        // Tiles per side: odd values lose the low bit, zero becomes one tile,
        // and the count saturates at the parameter limit or 128.
        function int unsigned tiles_of(logic [8:0] blocks);
            int unsigned t;
            int unsigned lim;
            t = {24'd0, blocks[8:1]};
            lim = CDXT1_MAX_SIDE_BLOCKS / 2;
            if (lim > 128) lim = 128;
            if (lim < 1) lim = 1;
            if (t < 1) t = 1;
            if (t > lim) t = lim;
            return t;
        endfunction

        // RGB565 to {red, green, blue} at eight bits each, by bit replication.
        function logic [23:0] widen_565(logic [15:0] c);
            return {c[15:11], c[15:13], c[10:5], c[10:9], c[4:0], c[4:2]};
        endfunction

        function string row_text(out_t r);
            return $sformatf("x=%0d y=%0d row=%0d px=%h %h %h %h last_row=%b last_block=%b",
                             r.block_x, r.block_y, r.row_in_block, r.pixel_left,
                             r.pixel_mid_left, r.pixel_mid_right, r.pixel_right,
                             r.last_row, r.last_block);
        endfunction

        function void note_block(in_t blk);
            logic [23:0] ca;
            logic [23:0] cb;
            logic [23:0] mid2;
            logic [23:0] mid3;
            logic four_color;
            logic end_of_image;
            int unsigned av;
            int unsigned bv;
            int unsigned tw;
            int unsigned th;
            palette_t pal;
            out_t r;
            ca = widen_565(blk.endpoint_first);
            cb = widen_565(blk.endpoint_second);
            four_color = blk.endpoint_first > blk.endpoint_second;
            for (int ch = 0; ch < 3; ch++) begin
                av = {24'd0, ca[8*ch +: 8]};
                bv = {24'd0, cb[8*ch +: 8]};
                if (four_color) begin
                    mid2[8*ch +: 8] = 8'((2 * av + bv + 1) / 3);
                end else begin
                    mid2[8*ch +: 8] = 8'((av + bv + 1) / 2);
                end
                mid3[8*ch +: 8] = 8'((av + 2 * bv + 1) / 3);
            end
            pal[0] = {8'hFF, ca};
            pal[1] = {8'hFF, cb};
            pal[2] = {8'hFF, mid2};
            // In three-color mode the last entry is the transparent one.
            pal[3] = {four_color ? 8'hFF : 8'h00, mid3};

            tw = tiles_of(width_reg);
            th = tiles_of(height_reg);
            end_of_image = (quad == 2'd3) && (tile_col + 1 >= tw) && (tile_row + 1 >= th);
            for (int row = 0; row < 4; row++) begin
                r.block_x = {tile_col, quad[0]};
                r.block_y = {tile_row, quad[1]};
                r.row_in_block = 2'(row);
                r.pixel_left = pal[blk.index_bits[31 - 8*row -: 2]];
                r.pixel_mid_left = pal[blk.index_bits[29 - 8*row -: 2]];
                r.pixel_mid_right = pal[blk.index_bits[27 - 8*row -: 2]];
                r.pixel_right = pal[blk.index_bits[25 - 8*row -: 2]];
                r.last_row = (row == 3);
                r.last_block = end_of_image;
                rows_due.push_back(r);
            end

            // Walk the 2x2 blocks of a tile, then tiles across, then down.
            quad = quad + 2'd1;
            if (quad == 2'd0) begin
                if (tile_col + 1 >= tw) begin
                    tile_col = '0;
                    if (tile_row + 1 >= th) tile_row = '0;
                    else tile_row = tile_row + 7'd1;
                end else begin
                    tile_col = tile_col + 7'd1;
                end
            end
        endfunction

        function void check_row(out_t got);
            out_t want;
            string bad;
            if (rows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row: %s", row_text(got));
                return;
            end
            want = rows_due.pop_front();
            rows_checked++;
            bad = "";
            if (got.block_x !== want.block_x) bad = {bad, " block_x"};
            if (got.block_y !== want.block_y) bad = {bad, " block_y"};
            if (got.row_in_block !== want.row_in_block) bad = {bad, " row_in_block"};
            if (got.pixel_left !== want.pixel_left) bad = {bad, " pixel_left"};
            if (got.pixel_mid_left !== want.pixel_mid_left) bad = {bad, " pixel_mid_left"};
            if (got.pixel_mid_right !== want.pixel_mid_right) bad = {bad, " pixel_mid_right"};
            if (got.pixel_right !== want.pixel_right) bad = {bad, " pixel_right"};
            if (got.last_row !== want.last_row) bad = {bad, " last_row"};
            if (got.last_block !== want.last_block) bad = {bad, " last_block"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("row mismatch in%s", bad);
                    $display("  expected %s", row_text(want));
                    $display("  actual   %s", row_text(got));
                end
            end else if (got.last_row && got.last_block) begin
                image_ends++;
            end
        endfunction

        function void flush_left();
            if (rows_due.size() != 0) begin
                mismatches += rows_due.size();
                $display("%0d expected rows never arrived", rows_due.size());
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_WIDTH_BLOCKS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    dxt1_row_board board;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned blocks_sent = 0;
    int unsigned size_settings = 1;

    // Width and height per phase; the first phase keeps the reset values.
    int unsigned phase_width[7] = '{256, 2, 7, 0, 511, 4, 256};
    int unsigned phase_height[7] = '{256, 2, 3, 1, 300, 8, 2};

    cmpr_dxt1_block_decoder_unit #(
        .MAX_SIDE_BLOCKS(CDXT1_MAX_SIDE_BLOCKS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Result side: check every accepted row and stall at random.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_row(m_data);
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Leaves valid high after acceptance; the caller lowers it when the burst ends.
    task automatic send_block(input in_t blk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= blk;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_block(blk);
        blocks_sent++;
    endtask

    task automatic wait_drained();
        while (board.rows_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_WIDTH_BLOCKS;
        cfg_wdata <= w;
        @(posedge aclk);
        board.set_size(REG_WIDTH_BLOCKS, w);
        cfg_index <= REG_HEIGHT_BLOCKS;
        cfg_wdata <= h;
        @(posedge aclk);
        board.set_size(REG_HEIGHT_BLOCKS, h);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Random blocks, most of them steered into a palette mode or to equal or extreme endpoints.
    function automatic in_t random_block();
        in_t b;
        logic [15:0] t;
        b.endpoint_first = 16'($urandom);
        b.endpoint_second = 16'($urandom);
        b.index_bits = $urandom;
        case ($urandom_range(0, 9))
            4, 5: begin
                if (b.endpoint_first < b.endpoint_second) begin
                    t = b.endpoint_first;
                    b.endpoint_first = b.endpoint_second;
                    b.endpoint_second = t;
                end
            end
            6, 7: begin
                if (b.endpoint_first > b.endpoint_second) begin
                    t = b.endpoint_first;
                    b.endpoint_first = b.endpoint_second;
                    b.endpoint_second = t;
                end
            end
            8: b.endpoint_second = b.endpoint_first;
            9: begin
                b.endpoint_first = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                b.endpoint_second = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0) b.index_bits = {16{2'($urandom_range(0, 3))}};
        return b;
    endfunction

    initial begin
        board = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < 7; p++) begin
            if (p < 3) begin
                send_idle_pct = 21;
                recv_idle_pct = 79;
            end else if (p < 5) begin
                send_idle_pct = 79;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p != 0) begin
                write_size(9'(phase_width[p]), 9'(phase_height[p]));
                size_settings++;
            end else begin
                send_block(in_t'{16'h0000, 16'h0000, 32'h0000_0000});
                send_block(in_t'{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF});
                // Four-color mode, every index in every row.
                send_block(in_t'{16'hFFFF, 16'h0000, 32'h1B1B_1B1B});
                // Three-color mode with the transparent entry.
                send_block(in_t'{16'h0000, 16'hFFFF, 32'hE4E4_E4E4});
                send_block(in_t'{16'hF800, 16'h07E0, 32'h55AA_FF00});
                send_block(in_t'{16'h07E0, 16'h001F, 32'hAA55_00FF});
                send_block(in_t'{16'h001F, 16'hF800, 32'h0123_4567});
                // Equal endpoints fall into three-color mode.
                send_block(in_t'{16'h1234, 16'h1234, 32'hFFFF_FFFF});
                send_block(in_t'{16'h8000, 16'h7FFF, 32'hC3C3_C3C3});
                send_block(in_t'{16'h0001, 16'h0000, 32'hFFFF_0000});
                send_block(in_t'{16'h0000, 16'h0001, 32'h0000_FFFF});
                send_block(in_t'{16'hFFFE, 16'hFFFF, 32'hAAAA_AAAA});
                send_block(in_t'{16'h7BEF, 16'h8410, 32'h5555_5555});
                send_block(in_t'{16'hFFFF, 16'hFFFE, 32'h3333_CCCC});
            end
            repeat (38) send_block(random_block());
            s_valid <= 1'b0;
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        board.flush_left();
        $display("Decoded %0d blocks into %0d checked rows under %0d image sizes.",
                 blocks_sent, board.rows_checked, size_settings);
        $display("Reached the end of an image %0d times.", board.image_ends);
        if (board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out waiting on the decoder");
        $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
src/cdxt1_pkg.sv
src/cdxt1_position.sv
src/cdxt1_palette.sv
src/cdxt1_row_emit.sv
src/cmpr_dxt1_block_decoder_unit.sv
src/cdxt1_checker.sv
sim/tb.sv
